// ----- rtl/core/modbus_input_register_responder_top_defines.svh -----
// assertion macros for the input register responder
`ifndef MODBUS_INPUT_REGISTER_RESPONDER_TOP_DEFINES_SVH
`define MODBUS_INPUT_REGISTER_RESPONDER_TOP_DEFINES_SVH

// same-cycle implication, checked on clk, off during reset
`define MIRR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mirr assertion failed");

// next-cycle implication, checked on clk, off during reset
`define MIRR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mirr assertion failed");

`endif

// ----- rtl/core/mirr_pkg.sv -----
// shared types and constants of the input register responder
package mirr_pkg;

	// operation codes
	localparam logic [1:0] OP_WRITE   = 2'd0;
	localparam logic [1:0] OP_PUBLISH = 2'd1;
	localparam logic [1:0] OP_PATCH   = 2'd2;
	localparam logic [1:0] OP_READ    = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ZERO_CNT = 2'd1;
	localparam logic [1:0] ST_BAD_ADDR = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	// protocol constants
	localparam logic [7:0] FC_READ_IR     = 8'h04;
	localparam logic [7:0] FC_EXCEPTION   = 8'h84;
	localparam logic [7:0] EX_BAD_VALUE   = 8'h03;
	localparam logic [7:0] EX_BAD_ADDRESS = 8'h02;

	// configuration register file: start and length for four zones
	localparam int CFG_ZONES   = 4;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic [15:0] ZONE_START_RST [CFG_ZONES] = '{16'd0, 16'd890, 16'd2100, 16'd4000};
	localparam logic [7:0]  ZONE_LEN_RST   [CFG_ZONES] = '{8'd94, 8'd7, 8'd23, 8'd40};

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] reg_addr;
		logic [15:0] write_data;
		logic [15:0] word_count;
		logic [15:0] resp_room;
	} request_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  function_code;
		logic [7:0]  byte_count_or_code;
		logic [15:0] first_word;
		logic [15:0] second_word;
		logic [1:0]  words_valid;
		logic        last;
	} result_t;

endpackage

// ----- rtl/core/modbus_input_register_responder_top.sv -----
// modbus function 4 responder with a double-buffered input register store
//
// A request is taken when start is high and busy is low. Ops: write one word
// into the back bank, publish (swap banks), patch one word of the front bank,
// or read word_count registers from reg_addr. Zones are searched one per
// cycle through a single range comparator, lowest zone first.
// Writes and patches go through the zone search, an address step and a
// write step. A read goes through the zone search and the address step to
// the first memory access, then reads one word at a time, since the store
// has a single port, giving results of two words. Exceptions (zero count,
// bad address, overflow) give one result. Each result sits on result for
// exactly one cycle with result_valid high; the receiver takes it then and
// cannot stall. Configuration writes (cfg_we, cfg_index, cfg_data) land at
// once and must be made only while busy is low; the block does not enforce
// it. After reset the block sweeps all 2 * ZONE_COUNT * ZONE_DEPTH words
// (1024 by default) to zero, one word a cycle, with busy high.
`include "modbus_input_register_responder_top_defines.svh"

module modbus_input_register_responder_top #(
	parameter int ZONE_DEPTH = 128,
	parameter int ZONE_COUNT = 4
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  mirr_pkg::request_t                     request,
	output logic                                   result_valid,
	output mirr_pkg::result_t                      result,
	input  logic                                   cfg_we,
	input  logic [mirr_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [mirr_pkg::CFG_DATA_W-1:0]        cfg_data
);

	localparam int BANK_WORDS  = ZONE_COUNT * ZONE_DEPTH;
	localparam int STORE_WORDS = 2 * BANK_WORDS;
	localparam int AW          = $clog2(STORE_WORDS);
	localparam int OW          = $clog2(ZONE_DEPTH);
	localparam int CW          = $clog2(ZONE_DEPTH + 1);
	localparam logic [1:0] ZONE_LAST = 2'(ZONE_COUNT - 1);
	localparam logic [7:0] DEPTH_MAX = 8'(ZONE_DEPTH);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SEARCH,
		S_ADDR,
		S_WRITE,
		S_RD_W0,
		S_RD_W1,
		S_RD_EMIT
	} state_t;

	state_t             state_q;
	logic [15:0]        zone_start_q [mirr_pkg::CFG_ZONES];
	logic [7:0]         zone_len_q [mirr_pkg::CFG_ZONES];
	logic [1:0]         zone_q;
	logic [1:0]         zone_hit_q;
	logic [OW-1:0]      off_q;
	logic [1:0]         op_q;
	logic [15:0]        reg_addr_q;
	logic [15:0]        data_q;
	logic [15:0]        count_q;
	logic               ovf_q;
	logic [CW-1:0]      remaining_q;
	logic [15:0]        w0_q;
	logic               front_q;
	logic [AW-1:0]      addr_q;
	mirr_pkg::result_t  result_q;
	logic               result_valid_q;

	logic [15:0]        store_mem [STORE_WORDS];
	logic [15:0]        rdata_q;
	logic               mem_we;
	logic [15:0]        mem_wdata;

	logic [15:0]        cmp_start;
	logic [7:0]         cmp_len;
	logic [7:0]         cmp_n;
	logic               cmp_hit;
	logic [OW-1:0]      cmp_off;
	logic               bank_sel;
	logic [1:0]         cfg_zone;

	function automatic mirr_pkg::result_t make_result(
		input logic [1:0]  status,
		input logic [7:0]  fc,
		input logic [7:0]  code,
		input logic [15:0] w0,
		input logic [15:0] w1,
		input logic [1:0]  valid,
		input logic        fin
	);
		mirr_pkg::result_t r;
		r.status             = status;
		r.function_code      = fc;
		r.byte_count_or_code = code;
		r.first_word         = w0;
		r.second_word        = w1;
		r.words_valid        = valid;
		r.last               = fin;
		return r;
	endfunction

	// shared range comparator: does the current zone hold the whole range
	always_comb begin
		cmp_start = zone_start_q[zone_q];
		cmp_len   = zone_len_q[zone_q];
		cmp_n     = (cmp_len > DEPTH_MAX) ? DEPTH_MAX : cmp_len;
		cmp_hit   = (cmp_n != 8'd0) && (reg_addr_q >= cmp_start) &&
			(({1'b0, reg_addr_q} + {1'b0, count_q}) <= ({1'b0, cmp_start} + {9'd0, cmp_n}));
		cmp_off   = OW'(reg_addr_q - cmp_start);
	end

	// back bank for writes, front bank for patches and reads
	assign bank_sel = (op_q == mirr_pkg::OP_WRITE) ? ~front_q : front_q;
	assign cfg_zone = cfg_index[2:1];

	// store write: zero sweep after reset, or one word write
	assign mem_we    = (state_q == S_CLEAR) || (state_q == S_WRITE);
	assign mem_wdata = (state_q == S_CLEAR) ? 16'd0 : data_q;

	// single-port word store with registered read data
	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[addr_q] <= mem_wdata;
		end
		rdata_q <= store_mem[addr_q];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mirr_pkg::CFG_ZONES; i++) begin
				zone_start_q[i] <= mirr_pkg::ZONE_START_RST[i];
				zone_len_q[i]   <= mirr_pkg::ZONE_LEN_RST[i];
			end
		end else if (cfg_we) begin
			if (cfg_index[0]) begin
				zone_len_q[cfg_zone] <= cfg_data[7:0];
			end else begin
				zone_start_q[cfg_zone] <= cfg_data;
			end
		end
	end

	// sequencer: zone search, store access and result streaming
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			addr_q         <= '0;
			front_q        <= 1'b0;
			zone_q         <= 2'd0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					if (addr_q == AW'(STORE_WORDS - 1)) begin
						state_q <= S_IDLE;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (start) begin
						op_q       <= request.op;
						reg_addr_q <= request.reg_addr;
						data_q     <= request.write_data;
						count_q    <= (request.op == mirr_pkg::OP_READ) ? request.word_count : 16'd1;
						ovf_q      <= ({2'b00, request.resp_room} <
							({1'b0, request.word_count, 1'b0} + 18'd2));
						zone_q     <= 2'd0;
						unique case (request.op)
							mirr_pkg::OP_PUBLISH: begin
								front_q <= ~front_q;
							end
							mirr_pkg::OP_READ: begin
								if (request.word_count == 16'd0) begin
									result_q <= make_result(mirr_pkg::ST_ZERO_CNT,
										mirr_pkg::FC_EXCEPTION, mirr_pkg::EX_BAD_VALUE,
										16'd0, 16'd0, 2'd0, 1'b1);
									result_valid_q <= 1'b1;
								end else begin
									state_q <= S_SEARCH;
								end
							end
							mirr_pkg::OP_WRITE, mirr_pkg::OP_PATCH: begin
								state_q <= S_SEARCH;
							end
						endcase
					end
				end
				S_SEARCH: begin
					if (cmp_hit) begin
						zone_hit_q  <= zone_q;
						off_q       <= cmp_off;
						remaining_q <= CW'(count_q);
						if ((op_q == mirr_pkg::OP_READ) && ovf_q) begin
							result_q <= make_result(mirr_pkg::ST_OVERFLOW, 8'd0, 8'd0,
								16'd0, 16'd0, 2'd0, 1'b1);
							result_valid_q <= 1'b1;
							state_q        <= S_IDLE;
						end else begin
							state_q <= S_ADDR;
						end
					end else if (zone_q == ZONE_LAST) begin
						if (op_q == mirr_pkg::OP_READ) begin
							result_q <= make_result(mirr_pkg::ST_BAD_ADDR,
								mirr_pkg::FC_EXCEPTION, mirr_pkg::EX_BAD_ADDRESS,
								16'd0, 16'd0, 2'd0, 1'b1);
							result_valid_q <= 1'b1;
						end
						state_q <= S_IDLE;
					end else begin
						zone_q <= zone_q + 1'b1;
					end
				end
				S_ADDR: begin
					addr_q <= AW'(int'(bank_sel) * BANK_WORDS + int'(zone_hit_q) * ZONE_DEPTH +
						int'(off_q));
					state_q <= (op_q == mirr_pkg::OP_READ) ? S_RD_W0 : S_WRITE;
				end
				S_WRITE: begin
					state_q <= S_IDLE;
				end
				S_RD_W0: begin
					addr_q  <= addr_q + 1'b1;
					state_q <= S_RD_W1;
				end
				S_RD_W1: begin
					if (remaining_q == CW'(1)) begin
						result_q <= make_result(mirr_pkg::ST_OK, mirr_pkg::FC_READ_IR,
							{count_q[6:0], 1'b0}, rdata_q, 16'd0, 2'd1, 1'b1);
						result_valid_q <= 1'b1;
						state_q        <= S_IDLE;
					end else begin
						w0_q    <= rdata_q;
						addr_q  <= addr_q + 1'b1;
						state_q <= S_RD_EMIT;
					end
				end
				S_RD_EMIT: begin
					result_q <= make_result(mirr_pkg::ST_OK, mirr_pkg::FC_READ_IR,
						{count_q[6:0], 1'b0}, w0_q, rdata_q, 2'd2, remaining_q == CW'(2));
					result_valid_q <= 1'b1;
					remaining_q    <= remaining_q - CW'(2);
					if (remaining_q == CW'(2)) begin
						state_q <= S_IDLE;
					end else begin
						addr_q  <= addr_q + 1'b1;
						state_q <= S_RD_W1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// exception results are single and carry no words
	`MIRR_ASSERT_NOW(a_exc_single, result_valid_q && (result_q.status != mirr_pkg::ST_OK), result_q.last && (result_q.words_valid == 2'd0))
	// only a read can cause a result in the next cycle
	`MIRR_ASSERT_NEXT(a_no_result_for_write, start && !busy && (request.op != mirr_pkg::OP_READ), !result_valid_q)
	// a stream that is not finished keeps the block busy
	`MIRR_ASSERT_NOW(a_stream_busy, result_valid_q && !result_q.last, busy)
	// no results during the clearing sweep
	`MIRR_ASSERT_NOW(a_clear_quiet, state_q == S_CLEAR, !result_valid_q)

endmodule
